// ===== design/hsh_pkg.sv =====
// shared types and constants of the selectable byte-stream hash
package hsh_pkg;

    // algorithm select codes
    localparam logic [1:0] SEL_DJB2   = 2'd0;
    localparam logic [1:0] SEL_FNV    = 2'd1;
    localparam logic [1:0] SEL_MURMUR = 2'd2;

    // hash constants
    localparam logic [31:0] DJB2_START = 32'd5381;
    localparam logic [31:0] FNV_START  = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME  = 32'd16777619;
    localparam logic [31:0] MM_C1      = 32'hcc9e2d51;
    localparam logic [31:0] MM_C2      = 32'h1b873593;
    localparam logic [31:0] MM_N       = 32'he6546b64;
    localparam logic [31:0] MM_F1      = 32'h85ebca6b;
    localparam logic [31:0] MM_F2      = 32'hc2b2ae35;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // classified command passed from front to back
    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
        logic       is_empty;
        logic       first;
        logic [1:0] sel;
    } t_cmd;

    // back-end sequencer states
    typedef enum logic [2:0] {
        ST_FETCH,
        ST_K1,
        ST_K2,
        ST_HMIX,
        ST_FIN,
        ST_FX,
        ST_F2,
        ST_EMIT
    } t_state;

endpackage

// ===== design/hsh_in_if.sv =====
// input channel: one message byte per item
interface hsh_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       is_last;
    logic       is_empty;

    modport source (output valid, output data_byte, output is_last, output is_empty,
                    input ready);
    modport sink   (input valid, input data_byte, input is_last, input is_empty,
                    output ready);
endinterface

// ===== design/hsh_out_if.sv =====
// output channel: one 32-bit hash per item
interface hsh_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] hash_value;

    modport source (output valid, output hash_value, input ready);
    modport sink   (input valid, input hash_value, output ready);
endinterface

// ===== design/hsh_front.sv =====
// front end: accepts items, holds the select register and marks message starts
module hsh_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_data,
    hsh_in_if.sink          i_in,
    input  logic            i_q_full,
    output logic            o_push,
    output hsh_pkg::t_cmd   o_cmd
);

    logic [1:0] r_hash_select;
    logic       r_in_msg;
    logic       n_in_msg;
    logic       w_accept;
    logic       w_drop;

    // accept whenever the queue has room
    assign i_in.ready = !i_q_full;
    assign w_accept   = i_in.valid && !i_q_full;

    // an empty item that does not end a message is dropped
    assign w_drop = i_in.is_empty && !i_in.is_last;
    assign o_push = w_accept && !w_drop;

    // command build
    always_comb begin
        o_cmd.data_byte = i_in.data_byte;
        o_cmd.is_last   = i_in.is_last;
        o_cmd.is_empty  = i_in.is_empty;
        o_cmd.first     = !r_in_msg;
        o_cmd.sel       = r_hash_select;
    end

    // message tracking
    always_comb begin
        n_in_msg = r_in_msg;
        if (o_push) begin
            n_in_msg = !i_in.is_last;
        end
    end

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash_select <= hsh_pkg::SEL_DJB2;
            r_in_msg      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_hash_select <= i_cfg_data;
            end
            r_in_msg <= n_in_msg;
        end
    end

endmodule

// ===== design/hsh_queue.sv =====
// short command queue between front and back
module hsh_queue #(
    parameter int DEPTH = hsh_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  hsh_pkg::t_cmd   i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output hsh_pkg::t_cmd   o_cmd
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    hsh_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          w_do_pop;

    assign o_full   = (r_count == CW'(DEPTH));
    assign o_valid  = (r_count != '0);
    assign o_cmd    = r_mem[r_rd_ptr];
    assign w_do_pop = i_pop && o_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && w_do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== design/hsh_back.sv =====
// back end: runs the selected hash over queued commands and holds the result
module hsh_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  hsh_pkg::t_cmd   i_cmd,
    output logic            o_pop,
    hsh_out_if.source       o_out
);

    hsh_pkg::t_state r_state;
    hsh_pkg::t_state n_state;

    logic [31:0] r_h;
    logic [31:0] n_h;
    logic [31:0] r_cnt;
    logic [31:0] n_cnt;
    logic [23:0] r_pend;
    logic [23:0] n_pend;
    logic [1:0]  r_pos;
    logic [1:0]  n_pos;
    logic [1:0]  r_sel;
    logic [1:0]  n_sel;
    logic [31:0] r_k;
    logic [31:0] n_k;
    logic        r_last;
    logic        n_last;
    logic        r_tail;
    logic        n_tail;
    logic        r_out_valid;
    logic        n_out_valid;
    logic [31:0] r_out_hash;
    logic [31:0] n_out_hash;

    // per-message base values, restarted on the first command of a message
    logic [31:0] w_h_b;
    logic [31:0] w_cnt_b;
    logic [23:0] w_pend_b;
    logic [1:0]  w_pos_b;
    logic [1:0]  w_sel_e;
    logic [31:0] w_start;
    logic        w_take;
    logic        w_out_free;
    logic [31:0] w_mul_a;
    logic [31:0] w_mul_b;
    logic [31:0] w_prod;
    logic [31:0] w_mix_x;
    logic [31:0] w_mix_r;
    logic [31:0] w_fx;

    function automatic logic [31:0] rotl15(input logic [31:0] x);
        rotl15 = {x[16:0], x[31:17]};
    endfunction

    function automatic logic [31:0] rotl13(input logic [31:0] x);
        rotl13 = {x[18:0], x[31:19]};
    endfunction

    // start value of the algorithm in the command
    always_comb begin
        case (i_cmd.sel)
            hsh_pkg::SEL_FNV:    w_start = hsh_pkg::FNV_START;
            hsh_pkg::SEL_MURMUR: w_start = '0;
            default:             w_start = hsh_pkg::DJB2_START;
        endcase
    end

    assign w_h_b    = i_cmd.first ? w_start : r_h;
    assign w_cnt_b  = i_cmd.first ? '0 : r_cnt;
    assign w_pend_b = i_cmd.first ? '0 : r_pend;
    assign w_pos_b  = i_cmd.first ? '0 : r_pos;
    assign w_sel_e  = i_cmd.first ? i_cmd.sel : r_sel;

    assign w_take     = (r_state == hsh_pkg::ST_FETCH) && i_q_valid;
    assign o_pop      = w_take;
    assign w_out_free = !r_out_valid || o_out.ready;

    // murmur block mix into the running hash, and fmix first step
    assign w_mix_x = r_h ^ r_k;
    assign w_mix_r = rotl13(w_mix_x);
    assign w_fx    = (r_h ^ r_cnt) ^ ((r_h ^ r_cnt) >> 16);

    // shared multiplier
    always_comb begin
        case (r_state)
            hsh_pkg::ST_FETCH: begin
                w_mul_a = w_h_b ^ {24'd0, i_cmd.data_byte};
                w_mul_b = hsh_pkg::FNV_PRIME;
            end
            hsh_pkg::ST_K1: begin
                w_mul_a = r_k;
                w_mul_b = hsh_pkg::MM_C1;
            end
            hsh_pkg::ST_K2: begin
                w_mul_a = rotl15(r_k);
                w_mul_b = hsh_pkg::MM_C2;
            end
            hsh_pkg::ST_FX: begin
                w_mul_a = w_fx;
                w_mul_b = hsh_pkg::MM_F1;
            end
            hsh_pkg::ST_F2: begin
                w_mul_a = r_h ^ (r_h >> 13);
                w_mul_b = hsh_pkg::MM_F2;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            hsh_pkg::ST_FETCH: begin
                if (i_q_valid) begin
                    if (w_sel_e == hsh_pkg::SEL_MURMUR) begin
                        if (!i_cmd.is_empty && w_pos_b == 2'd3) begin
                            n_state = hsh_pkg::ST_K1;
                        end else if (i_cmd.is_last) begin
                            n_state = hsh_pkg::ST_FIN;
                        end
                    end else if (i_cmd.is_last) begin
                        n_state = hsh_pkg::ST_EMIT;
                    end
                end
            end
            hsh_pkg::ST_K1: n_state = hsh_pkg::ST_K2;
            hsh_pkg::ST_K2: n_state = hsh_pkg::ST_HMIX;
            hsh_pkg::ST_HMIX: begin
                if (r_tail) begin
                    n_state = hsh_pkg::ST_FX;
                end else if (r_last) begin
                    n_state = hsh_pkg::ST_FIN;
                end else begin
                    n_state = hsh_pkg::ST_FETCH;
                end
            end
            hsh_pkg::ST_FIN: begin
                n_state = (r_pos != 2'd0) ? hsh_pkg::ST_K1 : hsh_pkg::ST_FX;
            end
            hsh_pkg::ST_FX: n_state = hsh_pkg::ST_F2;
            hsh_pkg::ST_F2: n_state = hsh_pkg::ST_EMIT;
            hsh_pkg::ST_EMIT: begin
                if (w_out_free) begin
                    n_state = hsh_pkg::ST_FETCH;
                end
            end
            default: n_state = hsh_pkg::ST_FETCH;
        endcase
    end

    // datapath and output register
    always_comb begin
        n_h         = r_h;
        n_cnt       = r_cnt;
        n_pend      = r_pend;
        n_pos       = r_pos;
        n_sel       = r_sel;
        n_k         = r_k;
        n_last      = r_last;
        n_tail      = r_tail;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_hash  = r_out_hash;
        case (r_state)
            hsh_pkg::ST_FETCH: begin
                if (w_take) begin
                    n_h    = w_h_b;
                    n_cnt  = w_cnt_b;
                    n_pend = w_pend_b;
                    n_pos  = w_pos_b;
                    n_sel  = w_sel_e;
                    n_last = i_cmd.is_last;
                    n_tail = 1'b0;
                    if (!i_cmd.is_empty) begin
                        n_cnt = w_cnt_b + 32'd1;
                        case (w_sel_e)
                            hsh_pkg::SEL_FNV: begin
                                n_h = w_prod;
                            end
                            hsh_pkg::SEL_MURMUR: begin
                                case (w_pos_b)
                                    2'd0: n_pend = {w_pend_b[23:8], i_cmd.data_byte};
                                    2'd1: n_pend = {w_pend_b[23:16], i_cmd.data_byte,
                                                    w_pend_b[7:0]};
                                    2'd2: n_pend = {i_cmd.data_byte, w_pend_b[15:0]};
                                    default: begin
                                        n_k    = {i_cmd.data_byte, w_pend_b};
                                        n_pend = '0;
                                    end
                                endcase
                                n_pos = w_pos_b + 2'd1;
                            end
                            default: begin
                                n_h = (w_h_b << 5) + w_h_b + {24'd0, i_cmd.data_byte};
                            end
                        endcase
                    end
                end
            end
            hsh_pkg::ST_K1: n_k = w_prod;
            hsh_pkg::ST_K2: n_k = w_prod;
            hsh_pkg::ST_HMIX: begin
                if (r_tail) begin
                    n_h = w_mix_x;
                end else begin
                    n_h = (w_mix_r << 2) + w_mix_r + hsh_pkg::MM_N;
                end
            end
            hsh_pkg::ST_FIN: begin
                if (r_pos != 2'd0) begin
                    n_k    = {8'd0, r_pend};
                    n_tail = 1'b1;
                end
            end
            hsh_pkg::ST_FX: n_h = w_prod;
            hsh_pkg::ST_F2: n_h = w_prod;
            hsh_pkg::ST_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_hash  = (r_sel == hsh_pkg::SEL_MURMUR) ? (r_h ^ (r_h >> 16)) : r_h;
                end
            end
            default: begin
                n_h = r_h;
            end
        endcase
    end

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hsh_pkg::ST_FETCH;
            r_out_valid <= 1'b0;
            r_last      <= 1'b0;
            r_tail      <= 1'b0;
            r_sel       <= hsh_pkg::SEL_DJB2;
            r_pos       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_last      <= n_last;
            r_tail      <= n_tail;
            r_sel       <= n_sel;
            r_pos       <= n_pos;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_h        <= n_h;
        r_cnt      <= n_cnt;
        r_pend     <= n_pend;
        r_k        <= n_k;
        r_out_hash <= n_out_hash;
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.hash_value = r_out_hash;

endmodule

// ===== design/selectable_byte_stream_hash_core.sv =====
// top level of the selectable byte-stream hash
// The block hashes a message that arrives one byte per item and returns one 32-bit hash
// after the item marked last: djb2, FNV-1a or MurmurHash3 x86_32 (seed 0), chosen by the
// select register when a message begins (code 3 runs djb2). A front end takes an item in
// every cycle while its command queue has room; the back end works through the queue.
// In the back end a djb2 or FNV-1a byte is hashed as it is taken, and the message end
// loads the result register in ST_EMIT once it is free. A Murmur3 byte that completes a
// 32-bit block is mixed in three steps, ST_K1, ST_K2 and ST_HMIX, with one shared 32x32
// multiplier. The Murmur3 end runs ST_FIN, a tail of one to three bytes through those
// steps, then ST_FX, ST_F2 and ST_EMIT. Within a message the back end takes one djb2 or
// FNV-1a byte per cycle, none in a Murmur3 block mix; the queue absorbs short bursts.
module selectable_byte_stream_hash_core #(
    parameter int QUEUE_DEPTH = hsh_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_data,
    hsh_in_if.sink     i_in,
    hsh_out_if.source  o_out
);

    logic          w_push;
    logic          w_full;
    logic          w_pop;
    logic          w_q_valid;
    hsh_pkg::t_cmd w_push_cmd;
    hsh_pkg::t_cmd w_pop_cmd;

    // front end
    hsh_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_q_full   (w_full),
        .o_push     (w_push),
        .o_cmd      (w_push_cmd)
    );

    // command queue
    hsh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_pop_cmd)
    );

    // back end
    hsh_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_cmd     (w_pop_cmd),
        .o_pop     (w_pop),
        .o_out     (o_out)
    );

endmodule

// ===== design/hsh_checker.sv =====
// port-level checks of the hash core, bound to the top level
module hsh_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_hash
);

    // a result waiting on the sink holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_hash)))
        else $error("result dropped or changed while stalled");

    // reset empties the result register
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // reset empties the queue, so items are taken at once
    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready)
        else $error("input not ready after reset");

endmodule

bind selectable_byte_stream_hash_core hsh_checker u_hsh_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_hash  (o_out.hash_value)
);

// ===== dv/selectable_byte_stream_hash_core_test.sv =====
// hash core testbench: directed and random messages checked against a local hash predictor
`timescale 1ns / 1ps

module selectable_byte_stream_hash_core_test;

    // select code 3 falls back to djb2
    localparam logic [1:0] SEL_DJB2_ALT = 2'd3;
    // cycles for the back end to empty its queue and finish a murmur3 tail
    localparam int SETTLE_CYCLES = 32;
    localparam int CYCLE_LIMIT   = 300000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_data;

    hsh_in_if  in_ch ();
    hsh_out_if out_ch ();

    selectable_byte_stream_hash_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // predictor state: register copy and the message in progress
    logic [1:0]  cur_select = hsh_pkg::SEL_DJB2;
    logic [1:0]  msg_select = hsh_pkg::SEL_DJB2;
    logic [31:0] acc_hash   = hsh_pkg::DJB2_START;
    logic [31:0] msg_bytes  = '0;
    logic [23:0] tail_word  = '0;
    logic [1:0]  tail_cnt   = '0;
    bit          msg_open   = 1'b0;

    logic [31:0] expected_hashes[$];
    logic [31:0] want_hash;

    int idle_pct    = 0;
    int ready_hold  = 0;
    int err_cnt     = 0;
    int item_cnt    = 0;
    int ignored_cnt = 0;
    int hash_cnt    = 0;
    int empty_msgs  = 0;
    int cycle_cnt   = 0;
    int algo_msgs[4] = '{0, 0, 0, 0};

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d hashes outstanding", $time, expected_hashes.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side stalls in random bursts while idle_pct is set
    always @(posedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold--;
            out_ch.ready <= 1'b0;
        end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            ready_hold = $urandom_range(0, 6);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // compare each hash with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_hashes.size() == 0) begin
                $display("%0t: hash_value expected none, actual %08h", $time, out_ch.hash_value);
                err_cnt++;
            end else begin
                want_hash = expected_hashes.pop_front();
                hash_cnt++;
                if (out_ch.hash_value !== want_hash) begin
                    $display("%0t: hash_value expected %08h, actual %08h",
                             $time, want_hash, out_ch.hash_value);
                    err_cnt++;
                end
            end
        end
    end

    // murmur3 block scramble
    function automatic logic [31:0] murmur_mix_k(input logic [31:0] k);
        logic [31:0] t;
        t = k * hsh_pkg::MM_C1;
        t = {t[16:0], t[31:17]};
        return t * hsh_pkg::MM_C2;
    endfunction

    // advance the predicted hash by one accepted item
    task automatic advance_hash(input logic [7:0] b, input logic last, input logic empty);
        logic [31:0] h;
        if (empty && !last) begin
            ignored_cnt++;
            return;
        end
        item_cnt++;
        // first item of a message latches the select code
        if (!msg_open) begin
            msg_select = cur_select;
            case (cur_select)
                hsh_pkg::SEL_FNV:    acc_hash = hsh_pkg::FNV_START;
                hsh_pkg::SEL_MURMUR: acc_hash = '0;
                default:             acc_hash = hsh_pkg::DJB2_START;
            endcase
            msg_bytes = '0;
            tail_word = '0;
            tail_cnt  = '0;
            msg_open  = 1'b1;
        end
        if (!empty) begin
            case (msg_select)
                hsh_pkg::SEL_FNV: begin
                    acc_hash = (acc_hash ^ {24'd0, b}) * hsh_pkg::FNV_PRIME;
                end
                hsh_pkg::SEL_MURMUR: begin
                    if (tail_cnt == 2'd3) begin
                        acc_hash ^= murmur_mix_k({b, tail_word});
                        acc_hash = {acc_hash[18:0], acc_hash[31:19]} * 32'd5 + hsh_pkg::MM_N;
                        tail_word = '0;
                        tail_cnt  = '0;
                    end else begin
                        tail_word[tail_cnt * 8 +: 8] = b;
                        tail_cnt++;
                    end
                end
                default: begin
                    acc_hash = (acc_hash << 5) + acc_hash + {24'd0, b};
                end
            endcase
            msg_bytes++;
        end
        // message end: murmur3 tail, length and finaliser
        if (last) begin
            h = acc_hash;
            if (msg_select == hsh_pkg::SEL_MURMUR) begin
                if (tail_cnt != 2'd0)
                    h ^= murmur_mix_k({8'd0, tail_word});
                h ^= msg_bytes;
                h ^= h >> 16;
                h = h * hsh_pkg::MM_F1;
                h ^= h >> 13;
                h = h * hsh_pkg::MM_F2;
                h ^= h >> 16;
            end
            expected_hashes.push_back(h);
            algo_msgs[msg_select]++;
            if (msg_bytes == 0)
                empty_msgs++;
            msg_open = 1'b0;
        end
    endtask

    // offer one item, with an optional gap before it
    task automatic send_item(input logic [7:0] b, input logic last, input logic empty);
        int gap;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            gap = $urandom_range(1, 7);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.is_last   <= last;
        in_ch.is_empty  <= empty;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        advance_hash(b, last, empty);
    endtask

    // hold the sender until every expected hash has come
    task automatic wait_for_hashes();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_hashes.size() != 0) @(posedge i_clk);
    endtask

    // change the algorithm once the block has gone quiet
    task automatic write_select(input logic [1:0] sel);
        wait_for_hashes();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= sel;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_select = sel;
    endtask

    // random message: mostly short, some long, a few empty, with stray markers
    task automatic send_random_message();
        int len;
        int pick;
        bit end_marker;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            len = 0;
        else if (pick < 15)
            len = $urandom_range(13, 40);
        else
            len = $urandom_range(1, 12);
        end_marker = (len == 0) || ($urandom_range(0, 4) == 0);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 29) == 0)
                wait_for_hashes();
            if ($urandom_range(0, 11) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            send_item(8'($urandom_range(0, 255)), !end_marker && (i == len - 1), 1'b0);
        end
        if (end_marker)
            send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
    endtask

    // zero-length messages under every select code, after a stray marker at idle
    task automatic test_zero_length();
        send_item(8'hA5, 1'b0, 1'b1);
        write_select(hsh_pkg::SEL_DJB2);
        send_item(8'hFF, 1'b1, 1'b1);
        write_select(hsh_pkg::SEL_FNV);
        send_item(8'h00, 1'b1, 1'b1);
        write_select(hsh_pkg::SEL_MURMUR);
        send_item(8'h5A, 1'b1, 1'b1);
        write_select(SEL_DJB2_ALT);
        send_item(8'hFF, 1'b1, 1'b1);
    endtask

    // extreme byte values, murmur3 single-byte tail and block plus three-byte tail
    task automatic test_byte_extremes();
        write_select(hsh_pkg::SEL_DJB2);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        write_select(hsh_pkg::SEL_FNV);
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        write_select(hsh_pkg::SEL_MURMUR);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'h55, 1'b0, 1'b0);
        send_item(8'hAA, 1'b0, 1'b0);
        send_item(8'h01, 1'b0, 1'b0);
        send_item(8'h80, 1'b0, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
    endtask

    // markers inside a message, and a message ended by a marker
    task automatic test_empty_markers();
        write_select(SEL_DJB2_ALT);
        send_item(8'hFF, 1'b0, 1'b1);
        send_item(8'h12, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h34, 1'b0, 1'b0);
        send_item(8'hFF, 1'b1, 1'b1);
        // whole block with no tail
        write_select(hsh_pkg::SEL_MURMUR);
        repeat (4) send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'h77, 1'b1, 1'b1);
    endtask

    // random messages under one select code
    task automatic test_random_messages(input logic [1:0] sel, input int n_items, input int pct);
        int first_cnt;
        write_select(sel);
        idle_pct  = pct;
        first_cnt = item_cnt;
        while (item_cnt - first_cnt < n_items)
            send_random_message();
    endtask

    // test sequence
    initial begin
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_data      <= hsh_pkg::SEL_DJB2;
        in_ch.valid     <= 1'b0;
        in_ch.data_byte <= '0;
        in_ch.is_last   <= 1'b0;
        in_ch.is_empty  <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        idle_pct = 20;
        test_zero_length();
        test_byte_extremes();
        test_empty_markers();
        test_random_messages(hsh_pkg::SEL_MURMUR, 350, 30);
        test_random_messages(hsh_pkg::SEL_DJB2, 250, 12);
        test_random_messages(hsh_pkg::SEL_FNV, 250, 30);
        test_random_messages(SEL_DJB2_ALT, 150, 0);
        test_random_messages(hsh_pkg::SEL_MURMUR, 200, 0);

        wait_for_hashes();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("run covered %0d hashed items, %0d stray markers, %0d hashes checked",
                 item_cnt, ignored_cnt, hash_cnt);
        $display("messages by code: djb2 %0d, fnv-1a %0d, murmur3 %0d, code 3 %0d, empty %0d",
                 algo_msgs[0], algo_msgs[1], algo_msgs[2], algo_msgs[3], empty_msgs);
        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== selectable_byte_stream_hash_core.f =====
design/hsh_pkg.sv
design/hsh_in_if.sv
design/hsh_out_if.sv
design/hsh_front.sv
design/hsh_queue.sv
design/hsh_back.sv
design/selectable_byte_stream_hash_core.sv
design/hsh_checker.sv
dv/selectable_byte_stream_hash_core_test.sv
